/* hdl/long_fir_convolver_dry_wet_unit_macros.svh */
// Assertion helpers used by the checker file.
`ifndef LONG_FIR_CONVOLVER_DRY_WET_UNIT_MACROS_SVH
`define LONG_FIR_CONVOLVER_DRY_WET_UNIT_MACROS_SVH

// Same-cycle implication, masked while in reset.
`define LFCDW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while in reset.
`define LFCDW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lfcdw_pkg.sv */
package lfcdw_pkg;

  // MAX_TAPS must be a power of two: history addressing wraps by truncation.
  localparam int MAX_TAPS    = 4096;
  localparam int SAMPLE_BITS = 16;

  localparam int PTR_W     = $clog2(MAX_TAPS);
  localparam int CNT_W     = $clog2(MAX_TAPS + 1);
  localparam int FRAC_BITS = SAMPLE_BITS - 1;
  localparam int PROD_W    = 2 * SAMPLE_BITS;
  localparam int ACC_W     = PROD_W + CNT_W;
  localparam int WET_W     = ACC_W - FRAC_BITS;

  // Fixed field widths.
  localparam int CMD_W      = 2;
  localparam int IDX_W      = 12;
  localparam int TAPS_W     = 13;
  localparam int MIX_W      = 9;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [MIX_W-1:0] WET_FULL = 9'd256;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = ~SAMPLE_MAX;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_COEF   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_COUNT = 1'b0,
    REG_WET_MIX   = 1'b1
  } reg_idx_t;

  // Sequencer to MAC datapath.
  typedef struct packed {
    logic clr;   // start of a new sample, zero the accumulator
    logic rd_v;  // read data from both memories is valid this cycle
    logic live;  // history entry was written since the last clear
  } mac_ctl_t;

  typedef struct packed {
    sample_t sample;
    logic    clipped;
  } res_t;

endpackage

/* hdl/lfcdw_ram.sv */
module lfcdw_ram #(
  parameter int  DEPTH = 16,
  parameter int  WIDTH = 8,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

/* hdl/lfcdw_mac.sv */
module lfcdw_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lfcdw_pkg::mac_ctl_t               ctl,
  input  lfcdw_pkg::sample_t                hist,
  input  lfcdw_pkg::sample_t                coef,
  output logic                              busy,
  output logic signed [lfcdw_pkg::ACC_W-1:0] acc_r
);
  import lfcdw_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctl.rd_v;
    end
  end

  // Product stage, then accumulate. Unwritten history reads as zero.
  always_ff @(posedge clk) begin
    prod_r <= ctl.live ? PROD_W'(hist) * PROD_W'(coef) : '0;
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign busy = prod_v_r;

endmodule

/* hdl/lfcdw_mix.sv */
module lfcdw_mix (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [lfcdw_pkg::ACC_W-1:0] acc,
  input  lfcdw_pkg::sample_t                 x,
  input  logic [lfcdw_pkg::MIX_W-1:0]        w,
  output logic                               done_r,
  output lfcdw_pkg::res_t                    res_r
);
  import lfcdw_pkg::*;

  localparam int DRY_W  = SAMPLE_BITS + MIX_W + 1;
  localparam int WETP_W = WET_W + MIX_W + 1;
  localparam int T_W    = WETP_W + 1;
  localparam int Y_W    = T_W - 8;

  localparam logic signed [Y_W-1:0] Y_MAX = (Y_W'(1) <<< (SAMPLE_BITS - 1)) - Y_W'(1);
  localparam logic signed [Y_W-1:0] Y_MIN = ~Y_MAX;

  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [MIX_W:0]    dry_gain;
  logic signed [MIX_W:0]    wet_gain;
  logic signed [WET_W-1:0]  wet_r;
  logic signed [MIX_W:0]    wgain_r;
  logic signed [DRY_W-1:0]  dry_r;
  logic signed [DRY_W-1:0]  dry2_r;
  logic signed [WETP_W-1:0] wetp_r;
  logic signed [T_W-1:0]    t_sum;
  logic signed [Y_W-1:0]    y;
  logic                     v1_r;
  logic                     v2_r;
  res_t                     res_nxt;

  assign acc_rnd  = acc + (ACC_W'(1) <<< (FRAC_BITS - 1));
  assign dry_gain = signed'({1'b0, WET_FULL - w});
  assign wet_gain = signed'({1'b0, w});

  // Round half up, weight, then round by 1/256 and saturate.
  assign t_sum = T_W'(wetp_r) + T_W'(dry2_r) + T_W'(128);
  assign y     = Y_W'(t_sum >>> 8);

  always_comb begin
    res_nxt.clipped = 1'b0;
    if (y > Y_MAX) begin
      res_nxt.sample  = SAMPLE_MAX;
      res_nxt.clipped = 1'b1;
    end else if (y < Y_MIN) begin
      res_nxt.sample  = SAMPLE_MIN;
      res_nxt.clipped = 1'b1;
    end else begin
      res_nxt.sample = y[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    wet_r   <= WET_W'(acc_rnd >>> FRAC_BITS);
    dry_r   <= DRY_W'(x) * DRY_W'(dry_gain);
    wgain_r <= wet_gain;
    wetp_r  <= WETP_W'(wet_r) * WETP_W'(wgain_r);
    dry2_r  <= dry_r;
    res_r   <= res_nxt;
  end

endmodule

/* hdl/long_fir_convolver_dry_wet_unit.sv */
// Long FIR convolver with dry/wet mix. Each request carries a command: process
// a sample (one result), write one coefficient, or clear the sample history (no
// result). A sample with tap_count taps in use runs one multiply-accumulate per
// tap, driven by one read per cycle from the history and coefficient memories,
// then passes the memory and multiplier registers and a three-stage mix before
// the block takes the next request. With tap_count zero the sample passes
// through the EMIT state back to idle; coefficient writes and clears leave the
// block idle. The result sits in an output register, so the next request is
// taken while it waits. Clear is instant: a fill count marks which history
// entries were written since, so no memory sweep runs after reset or clear.
// Coefficients are undefined until written. The user must write configuration
// only while no request is in flight; the block does not enforce this.
module long_fir_convolver_dry_wet_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [lfcdw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lfcdw_pkg::CFG_DATA_W-1:0]    cfg_data,
  // requests
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lfcdw_pkg::CMD_W-1:0]         in_command,
  input  logic signed [lfcdw_pkg::SAMPLE_BITS-1:0] in_sample_in,
  input  logic signed [lfcdw_pkg::SAMPLE_BITS-1:0] in_coef_value,
  input  logic [lfcdw_pkg::IDX_W-1:0]         in_coef_index,
  // results
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lfcdw_pkg::SAMPLE_BITS-1:0] out_sample_out,
  output logic                                out_clipped
);
  import lfcdw_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_MIX,
    ST_EMIT
  } state_t;

  state_t            state_r;

  // Registers
  logic [TAPS_W-1:0] tap_count_r;
  logic [MIX_W-1:0]  wet_mix_r;

  // History bookkeeping: next write pointer and count of live entries
  logic [PTR_W-1:0]  wp_r;
  logic [CNT_W-1:0]  fill_r;

  // Per-sample context
  logic [CNT_W-1:0]  k_r;
  logic [CNT_W-1:0]  taps_r;
  logic [PTR_W-1:0]  base_r;
  sample_t           x_r;
  logic [MIX_W-1:0]  w_r;
  logic              rd_v_r;
  logic              live_r;
  logic              mix_start_r;
  res_t              res_r;

  // Output register
  logic              out_valid_r;
  sample_t           out_sample_r;
  logic              out_clipped_r;

  logic              accept;
  cmd_t              cmd;
  logic [CNT_W-1:0]  taps_c;
  logic [MIX_W-1:0]  w_c;
  logic              issue;
  logic [PTR_W-1:0]  rd_pos;
  logic              hist_live;
  logic              hist_we;
  logic              coef_we;
  sample_t           hist_q;
  sample_t           coef_q;
  mac_ctl_t          mac_ctl;
  logic              mac_busy;
  logic signed [ACC_W-1:0] acc;
  logic              mix_done;
  res_t              mix_res;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign cmd      = cmd_t'(in_command);

  // Oversized settings saturate
  assign taps_c = (32'(tap_count_r) > 32'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : CNT_W'(tap_count_r);
  assign w_c    = (wet_mix_r > WET_FULL) ? WET_FULL : wet_mix_r;

  // New sample lands at wp; tap k reads k slots back, wrapping.
  assign hist_we = accept && (cmd == CMD_SAMPLE) && (taps_c != '0);
  assign coef_we = accept && (cmd == CMD_COEF) && (32'(in_coef_index) < 32'(MAX_TAPS));

  assign issue     = (state_r == ST_MAC) && (k_r < taps_r);
  assign rd_pos    = base_r - PTR_W'(k_r);
  // Since a clear, slots are filled from zero upward: below fill means written.
  assign hist_live = CNT_W'(rd_pos) < fill_r;

  assign mac_ctl.clr  = hist_we;
  assign mac_ctl.rd_v = rd_v_r;
  assign mac_ctl.live = live_r;

  lfcdw_ram #(.DEPTH(MAX_TAPS), .WIDTH(SAMPLE_BITS)) u_hist_ram (
    .clk     (clk),
    .we      (hist_we),
    .waddr   (wp_r),
    .wdata   (in_sample_in),
    .raddr   (rd_pos),
    .rdata_r (hist_q)
  );

  lfcdw_ram #(.DEPTH(MAX_TAPS), .WIDTH(SAMPLE_BITS)) u_coef_ram (
    .clk     (clk),
    .we      (coef_we),
    .waddr   (PTR_W'(in_coef_index)),
    .wdata   (in_coef_value),
    .raddr   (PTR_W'(k_r)),
    .rdata_r (coef_q)
  );

  lfcdw_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .hist  (hist_q),
    .coef  (coef_q),
    .busy  (mac_busy),
    .acc_r (acc)
  );

  lfcdw_mix u_mix (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mix_start_r),
    .acc    (acc),
    .x      (x_r),
    .w      (w_r),
    .done_r (mix_done),
    .res_r  (mix_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_count_r <= '0;
      wet_mix_r   <= WET_FULL;
      wp_r        <= '0;
      fill_r      <= '0;
      k_r         <= '0;
      rd_v_r      <= 1'b0;
      live_r      <= 1'b0;
      mix_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_v_r      <= issue;
      live_r      <= issue && hist_live;
      // last product has been accumulated
      mix_start_r <= (state_r == ST_MAC) && !issue && !rd_v_r && !mac_busy;

      // load from EMIT, drop once the receiver takes it
      if ((state_r == ST_EMIT) && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_TAP_COUNT: tap_count_r <= TAPS_W'(cfg_data);
          REG_WET_MIX:   wet_mix_r   <= cfg_data[MIX_W-1:0];
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_SAMPLE: begin
                x_r <= in_sample_in;
                w_r <= w_c;
                if (taps_c == '0) begin
                  // pass-through, history untouched
                  res_r.sample  <= in_sample_in;
                  res_r.clipped <= 1'b0;
                  state_r       <= ST_EMIT;
                end else begin
                  taps_r  <= taps_c;
                  base_r  <= wp_r;
                  wp_r    <= wp_r + PTR_W'(1);
                  if (fill_r != CNT_W'(MAX_TAPS)) begin
                    fill_r <= fill_r + CNT_W'(1);
                  end
                  k_r     <= '0;
                  state_r <= ST_MAC;
                end
              end
              CMD_CLEAR: begin
                wp_r   <= '0;
                fill_r <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_MAC: begin
          if (issue) begin
            k_r <= k_r + CNT_W'(1);
          end else if (!rd_v_r && !mac_busy) begin
            state_r <= ST_MIX;
          end
        end
        ST_MIX: begin
          if (mix_done) begin
            res_r   <= mix_res;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_sample_r  <= res_r.sample;
            out_clipped_r <= res_r.clipped;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clipped_r;

endmodule

/* hdl/lfcdw_checker.sv */
`include "long_fir_convolver_dry_wet_unit_macros.svh"

module lfcdw_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic [lfcdw_pkg::CMD_W-1:0]         in_command,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [lfcdw_pkg::SAMPLE_BITS-1:0] out_sample_out,
  input logic                                out_clipped
);
  import lfcdw_pkg::*;

  // held result keeps its payload
  `LFCDW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_sample_out) && $stable(out_clipped), "stalled result changed")

  // the block is busy in the cycle after it accepts a sample request
  `LFCDW_ASSERT_NEXT(a_busy_after_sample, clk, rst_n, in_valid && !in_stall && in_command == CMD_SAMPLE, in_stall, "ready right after sample request")

  // a new result only follows a busy cycle
  `LFCDW_ASSERT_NOW(a_result_after_busy, clk, rst_n, $rose(out_valid), $past(in_stall), "result without work")

  // clipping only reports full-scale values
  `LFCDW_ASSERT_NOW(a_clip_full_scale, clk, rst_n, out_valid && out_clipped, out_sample_out == SAMPLE_MAX || out_sample_out == SAMPLE_MIN, "clip flag on in-range sample")

endmodule

bind long_fir_convolver_dry_wet_unit lfcdw_checker u_lfcdw_checker (.*);
